>>> sv/pprt_pkg.sv
package pprt_pkg;

	// Table geometry
	localparam int NUM_PARTITIONS       = 64;
	localparam int PAGES_PER_BLOCK      = 256;
	localparam int PAGES_PER_PARTITION  = 1024;
	localparam int BLOCKS_PER_PARTITION = 4;
	localparam int NUM_BLOCKS           = 4096;

	localparam int PART_W      = 6;
	localparam int WORD_IDX_W  = 5;
	localparam int BM_DEPTH    = NUM_PARTITIONS * 32;
	localparam int BM_AW       = PART_W + WORD_IDX_W;
	localparam int SLOT_IDX_W  = 3;
	localparam int SLOT_DEPTH  = NUM_PARTITIONS * 8;
	localparam int SLOT_AW     = PART_W + SLOT_IDX_W;
	localparam int SLOT_W      = 13;
	localparam int BLOCK_W     = 12;
	localparam int PPB_W       = 8;
	localparam int LPN_W       = 24;
	localparam int PPN_W       = 20;
	localparam int OFF_W       = 10;
	localparam int RANK_W      = 11;
	localparam int HDR_W       = LPN_W + PPN_W;
	localparam int CNT_W       = BM_AW;

	localparam logic [SLOT_W-1:0] SLOT_RECLAIMED = 13'h1000;

	// Action codes
	localparam logic [2:0] ACT_HEADER  = 3'd0;
	localparam logic [2:0] ACT_MARK    = 3'd1;
	localparam logic [2:0] ACT_SET     = 3'd2;
	localparam logic [2:0] ACT_RECLAIM = 3'd3;
	localparam logic [2:0] ACT_LOOKUP  = 3'd4;

	// Status codes
	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_MAPPED    = 3'd1;
	localparam logic [2:0] ST_UNMAPPED  = 3'd2;
	localparam logic [2:0] ST_RECLAIMED = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;

	typedef struct packed {
		logic [2:0]  action;
		logic [5:0]  partition;
		logic [23:0] lpn;
		logic [9:0]  page_offset;
		logic [19:0] start_ppn;
		logic [2:0]  slot;
		logic [11:0] block;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [19:0] ppn;
	} rsp_t;

	typedef enum logic [1:0] {
		RS_DONE,
		RS_RANGE,
		RS_MAP,
		RS_SLOT
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     sweep_all;
		logic     clr_we;
		logic     cnt_clr;
		logic     cnt_inc;
		logic     hdr_we;
		logic     mark_we;
		logic     slot_we;
		logic     off_load;
		logic     scan_rd;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic       part_bad;
		logic       off_bad;
		logic       slot_bad;
		logic       lk_bad;
		logic       scan_end;
		logic       clr_end;
		logic       sweep_end;
		logic       need_slot;
		logic       out_free;
	} sts_t;

	// Count set bits of a word
	function automatic logic [5:0] ones32(input logic [31:0] w);
		logic [31:0] v;
		logic [31:0] p;
		begin
			v = w - ((w >> 1) & 32'h55555555);
			v = (v & 32'h33333333) + ((v >> 2) & 32'h33333333);
			v = (v + (v >> 4)) & 32'h0f0f0f0f;
			p = v * 32'h01010101;
			ones32 = p[29:24];
		end
	endfunction

endpackage

>>> sv/partition_page_rank_translate.sv
// Steps: a lookup checks the range, scans the bitmap words up to the lpn offset and maps
//   the rank, reading a block slot when needed; an out-of-range lookup stops after the check;
//   set header clears the bitmap row and slots of its partition; mark page is a read-modify-write.
// Throughput: one word in flight; the next word is taken when the response word is offered.
// Reset: arst_n asynchronous, active low; afterward a clearing pass over
//   the bitmap and slot memories runs with req_stall high.
module partition_page_rank_translate (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pprt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pprt_pkg::rsp_t rsp
);
	import pprt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pprt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pprt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

>>> sv/pprt_ram.sv
module pprt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/pprt_dp.sv
module pprt_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  pprt_pkg::req_t  req,
	input  pprt_pkg::cmd_t  cmd,
	output pprt_pkg::sts_t  sts,
	input  logic            rsp_stall,
	output logic            rsp_valid,
	output pprt_pkg::rsp_t  rsp
);
	import pprt_pkg::*;

	req_t              item_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [OFF_W-1:0]  off_q;
	logic              dv_q;
	logic [WORD_IDX_W-1:0] wd_q;
	logic [RANK_W-1:0] rank_q;
	logic              hit_q;
	rsp_t              res_q;
	rsp_t              out_q;
	logic              out_valid_q;

	logic [HDR_W-1:0]  hdr_rd;
	logic [LPN_W-1:0]  start_l;
	logic [PPN_W-1:0]  start_p;
	logic [31:0]       bm_rd;
	logic [SLOT_W-1:0] slot_rd;

	logic              bm_we;
	logic [BM_AW-1:0]  bm_addr;
	logic [31:0]       bm_wdata;
	logic              slot_we;
	logic [SLOT_AW-1:0] slot_waddr;
	logic [SLOT_W-1:0] slot_wdata;
	logic [SLOT_AW-1:0] slot_raddr;

	logic [LPN_W:0]    diff;
	logic [WORD_IDX_W-1:0] wi;
	logic [4:0]        rem;
	logic [31:0]       top_mask;
	logic [5:0]        pc;
	logic [8:0]        span;
	logic [RANK_W-1:0] r;
	logic [3:0]        idx;
	logic              first_blk;
	rsp_t              res_map;
	rsp_t              res_slot;
	rsp_t              res_nxt;

	assign start_l = hdr_rd[HDR_W-1:PPN_W];
	assign start_p = hdr_rd[PPN_W-1:0];

	// Header store: start logical and start physical page
	pprt_ram #(.WIDTH(HDR_W), .DEPTH(NUM_PARTITIONS)) u_hdr (
		.clk   (clk),
		.we    (cmd.hdr_we),
		.waddr (item_q.partition),
		.wdata ({item_q.lpn, item_q.start_ppn}),
		.raddr (item_q.partition),
		.rdata (hdr_rd)
	);

	// Bitmap store
	assign bm_we = cmd.clr_we | cmd.mark_we;
	always_comb begin
		if (cmd.sweep_all) begin
			bm_addr = cnt_q;
		end else if (item_q.action == ACT_MARK) begin
			bm_addr = {item_q.partition, item_q.page_offset[OFF_W-1:5]};
		end else begin
			bm_addr = {item_q.partition, cnt_q[WORD_IDX_W-1:0]};
		end
	end
	assign bm_wdata = cmd.clr_we ? 32'h0 :
		(bm_rd | (32'h80000000 >> item_q.page_offset[4:0]));

	pprt_ram #(.WIDTH(32), .DEPTH(BM_DEPTH)) u_bm (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_addr),
		.wdata (bm_wdata),
		.raddr (bm_addr),
		.rdata (bm_rd)
	);

	// Block slot store
	assign slot_we = cmd.clr_we | cmd.slot_we;
	always_comb begin
		if (cmd.sweep_all) begin
			slot_waddr = cnt_q[SLOT_AW-1:0];
		end else if (cmd.clr_we) begin
			slot_waddr = {item_q.partition, cnt_q[SLOT_IDX_W-1:0]};
		end else begin
			slot_waddr = {item_q.partition, item_q.slot};
		end
	end
	assign slot_wdata = (cmd.clr_we || item_q.action == ACT_RECLAIM) ? SLOT_RECLAIMED :
		{1'b0, item_q.block};
	assign slot_raddr = {item_q.partition, idx[SLOT_IDX_W-1:0]};

	pprt_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_DEPTH)) u_slot (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rd)
	);

	// Offset and rank helpers
	assign diff     = {1'b0, item_q.lpn} - {1'b0, start_l};
	assign wi       = off_q[OFF_W-1:5];
	assign rem      = off_q[4:0];
	assign top_mask = ~(32'hffffffff >> rem);
	assign pc       = (wd_q == wi) ? ones32(bm_rd & top_mask) : ones32(bm_rd);

	// Translation from the final rank
	assign span      = 9'(PAGES_PER_BLOCK) - {1'b0, start_p[PPB_W-1:0]};
	assign first_blk = rank_q < RANK_W'(span);
	assign r         = rank_q - RANK_W'(span);
	assign idx       = 4'd1 + 4'(r >> PPB_W);

	always_comb begin
		res_map = '0;
		if (!hit_q) begin
			res_map.status = ST_UNMAPPED;
		end else if (first_blk) begin
			res_map.status = ST_MAPPED;
			res_map.ppn    = start_p + PPN_W'(rank_q);
		end else begin
			res_map.status = ST_RECLAIMED;
		end
		res_slot = '0;
		if (slot_rd[SLOT_W-1]) begin
			res_slot.status = ST_RECLAIMED;
		end else begin
			res_slot.status = ST_MAPPED;
			res_slot.ppn    = PPN_W'({slot_rd[BLOCK_W-1:0], r[PPB_W-1:0]});
		end
		case (cmd.res_sel)
			RS_DONE:  res_nxt = '{status: ST_DONE, ppn: '0};
			RS_RANGE: res_nxt = '{status: ST_RANGE, ppn: '0};
			RS_MAP:   res_nxt = res_map;
			RS_SLOT:  res_nxt = res_slot;
			default:  res_nxt = '{status: ST_DONE, ppn: '0};
		endcase
	end

	// Status to the controller
	assign sts.action    = item_q.action;
	assign sts.part_bad  = 32'(item_q.partition) >= NUM_PARTITIONS;
	assign sts.off_bad   = 32'(item_q.page_offset) >= PAGES_PER_PARTITION;
	assign sts.slot_bad  = 32'(item_q.slot) > BLOCKS_PER_PARTITION;
	assign sts.lk_bad    = diff[LPN_W] | (|diff[LPN_W-1:OFF_W]);
	assign sts.scan_end  = cnt_q[WORD_IDX_W-1:0] == wi;
	assign sts.clr_end   = &cnt_q[WORD_IDX_W-1:0];
	assign sts.sweep_end = &cnt_q;
	assign sts.need_slot = hit_q & ~first_blk & (32'(idx) <= BLOCKS_PER_PARTITION);
	assign sts.out_free  = ~out_valid_q | ~rsp_stall;

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
		if (cmd.off_load) begin
			off_q <= diff[OFF_W-1:0];
		end
		wd_q <= cnt_q[WORD_IDX_W-1:0];
		if (cmd.cnt_clr) begin
			rank_q <= '0;
			hit_q  <= 1'b0;
		end else if (dv_q) begin
			rank_q <= rank_q + RANK_W'(pc);
			if (wd_q == wi) begin
				hit_q <= bm_rd[5'd31 - rem];
			end
		end
		if (cmd.res_load) begin
			res_q <= res_nxt;
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	// Control registers: counter, read-valid flag, output-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			dv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			dv_q <= cmd.scan_rd;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

>>> sv/pprt_ctrl.sv
module pprt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pprt_pkg::sts_t sts,
	output pprt_pkg::cmd_t cmd
);
	import pprt_pkg::*;

	typedef enum logic [3:0] {
		S_RST,
		S_IDLE,
		S_DEC,
		S_CLR,
		S_MWR,
		S_LCHK,
		S_LSCAN,
		S_LLAST,
		S_LMAP,
		S_LSLOT,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Decode commands and next state
	always_comb begin
		cmd         = '0;
		cmd.res_sel = RS_DONE;
		state_nxt   = state_q;
		case (state_q)
			S_RST: begin
				cmd.sweep_all = 1'b1;
				cmd.clr_we    = 1'b1;
				cmd.cnt_inc   = 1'b1;
				if (sts.sweep_end) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.action > ACT_LOOKUP) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_FIN;
				end else if (sts.part_bad) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RS_RANGE;
					state_nxt    = S_FIN;
				end else begin
					case (sts.action)
						ACT_HEADER: begin
							cmd.hdr_we  = 1'b1;
							cmd.cnt_clr = 1'b1;
							state_nxt   = S_CLR;
						end
						ACT_MARK: begin
							if (sts.off_bad) begin
								cmd.res_load = 1'b1;
								cmd.res_sel  = RS_RANGE;
								state_nxt    = S_FIN;
							end else begin
								state_nxt = S_MWR;
							end
						end
						ACT_SET, ACT_RECLAIM: begin
							cmd.res_load = 1'b1;
							if (sts.slot_bad) begin
								cmd.res_sel = RS_RANGE;
							end else begin
								cmd.slot_we = 1'b1;
							end
							state_nxt = S_FIN;
						end
						default: begin
							state_nxt = S_LCHK;
						end
					endcase
				end
			end
			S_CLR: begin
				cmd.clr_we  = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.clr_end) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_FIN;
				end
			end
			S_MWR: begin
				cmd.mark_we  = 1'b1;
				cmd.res_load = 1'b1;
				state_nxt    = S_FIN;
			end
			S_LCHK: begin
				if (sts.lk_bad) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RS_RANGE;
					state_nxt    = S_FIN;
				end else begin
					cmd.off_load = 1'b1;
					cmd.cnt_clr  = 1'b1;
					state_nxt    = S_LSCAN;
				end
			end
			S_LSCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_end) begin
					state_nxt = S_LLAST;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			S_LLAST: begin
				state_nxt = S_LMAP;
			end
			S_LMAP: begin
				if (sts.need_slot) begin
					state_nxt = S_LSLOT;
				end else begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RS_MAP;
					state_nxt    = S_FIN;
				end
			end
			S_LSLOT: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = RS_SLOT;
				state_nxt    = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RST;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign req_stall = state_q != S_IDLE;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import pprt_pkg::*;

	localparam int SLOTS_PP = BLOCKS_PER_PARTITION + 1;
	localparam int WORDS_PP = PAGES_PER_PARTITION / 32;
	localparam int LIMIT_CYCLES = 1500000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	partition_page_rank_translate dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// Shadow translation table
	logic [31:0]       bitmap_sh [NUM_PARTITIONS*WORDS_PP];
	logic [LPN_W-1:0]  start_lpn_sh [NUM_PARTITIONS];
	logic [PPN_W-1:0]  start_ppn_sh [NUM_PARTITIONS];
	logic [SLOT_W-1:0] slot_sh [NUM_PARTITIONS*SLOTS_PP];
	bit                hdr_set [NUM_PARTITIONS];

	rsp_t expected_rsp_q[$];
	int   mismatches;
	int   cycle_count;
	bit   calm;
	int   idle_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort on runaway
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("partition_page_rank_translate test failed");
			$finish;
		end
	end

	// Translate one request against the shadow table and update it
	function automatic rsp_t translate_page(input req_t r);
		rsp_t o;
		int p, off, rank, span, rr, idx;
		logic [SLOT_W-1:0] s;
		o = '0;
		p = int'(r.partition);
		o.status = ST_DONE;
		if (r.action > ACT_LOOKUP) return o;
		if (p >= NUM_PARTITIONS) begin
			o.status = ST_RANGE;
			return o;
		end
		case (r.action)
			ACT_HEADER: begin
				start_lpn_sh[p] = r.lpn;
				start_ppn_sh[p] = r.start_ppn;
				hdr_set[p] = 1'b1;
				for (int i = 0; i < WORDS_PP; i++) bitmap_sh[p*WORDS_PP+i] = '0;
				for (int i = 0; i < SLOTS_PP; i++) slot_sh[p*SLOTS_PP+i] = SLOT_RECLAIMED;
			end
			ACT_MARK: begin
				if (r.page_offset >= PAGES_PER_PARTITION) o.status = ST_RANGE;
				else bitmap_sh[p*WORDS_PP + r.page_offset/32][31 - r.page_offset%32] = 1'b1;
			end
			ACT_SET, ACT_RECLAIM: begin
				if (r.slot > BLOCKS_PER_PARTITION) o.status = ST_RANGE;
				else slot_sh[p*SLOTS_PP + r.slot] =
					(r.action == ACT_SET) ? {1'b0, r.block} : SLOT_RECLAIMED;
			end
			default: begin
				if (r.lpn < start_lpn_sh[p] ||
				    r.lpn - start_lpn_sh[p] >= PAGES_PER_PARTITION) begin
					o.status = ST_RANGE;
					return o;
				end
				off = r.lpn - start_lpn_sh[p];
				if (!bitmap_sh[p*WORDS_PP + off/32][31 - off%32]) begin
					o.status = ST_UNMAPPED;
					return o;
				end
				rank = 0;
				for (int i = 0; i < off; i++)
					rank += bitmap_sh[p*WORDS_PP + i/32][31 - i%32];
				span = PAGES_PER_BLOCK - start_ppn_sh[p] % PAGES_PER_BLOCK;
				if (rank < span) begin
					o.status = ST_MAPPED;
					o.ppn = 20'(start_ppn_sh[p] + rank);
				end else begin
					rr = rank - span;
					idx = 1 + rr / PAGES_PER_BLOCK;
					if (idx > BLOCKS_PER_PARTITION) begin
						o.status = ST_RECLAIMED;
					end else begin
						s = slot_sh[p*SLOTS_PP + idx];
						if (s[SLOT_W-1]) o.status = ST_RECLAIMED;
						else begin
							o.status = ST_MAPPED;
							o.ppn = 20'(s[BLOCK_W-1:0] * PAGES_PER_BLOCK +
								rr % PAGES_PER_BLOCK);
						end
					end
				end
			end
		endcase
		return o;
	endfunction

	// Send one word, predicting its response at acceptance
	task automatic send_req(input req_t r);
		while (!calm && $urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		expected_rsp_q.push_back(translate_page(r));
	endtask

	// Randomize the response stall
	always @(posedge clk) begin
		if (arst_n)
			rsp_stall <= !calm && ($urandom_range(99) < idle_pct);
	end

	// Check each accepted response against the oldest prediction
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word: %h", rsp);
			end else begin
				e = expected_rsp_q.pop_front();
				if (e.status !== rsp.status || e.ppn !== rsp.ppn) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp status %0d ppn %h, got status %0d ppn %h",
							e.status, e.ppn, rsp.status, rsp.ppn);
				end
			end
		end
	end

	function automatic req_t blank_req(input logic [2:0] a, input int p);
		req_t r;
		r = '0;
		r.action = a;
		r.partition = 6'(p);
		return r;
	endfunction

	task automatic do_header(input int p, input logic [23:0] l, input logic [19:0] s);
		req_t r;
		r = blank_req(ACT_HEADER, p);
		r.lpn = l;
		r.start_ppn = s;
		send_req(r);
	endtask

	task automatic do_mark(input int p, input int off);
		req_t r;
		r = blank_req(ACT_MARK, p);
		r.page_offset = 10'(off);
		send_req(r);
	endtask

	task automatic do_slot(input logic [2:0] a, input int p, input int sl, input int b);
		req_t r;
		r = blank_req(a, p);
		r.slot = 3'(sl);
		r.block = 12'(b);
		send_req(r);
	endtask

	task automatic do_lookup(input int p, input logic [23:0] l);
		req_t r;
		r = blank_req(ACT_LOOKUP, p);
		r.lpn = l;
		send_req(r);
	endtask

	// Directed corners: extremes, every action, out-of-range and unused codes
	task automatic test_directed();
		req_t r;
		calm = 1'b1;
		do_header(0, 24'd100, 20'd250);
		do_header(63, 24'hFFFC00, 20'hFFFFF);
		do_mark(0, 0);
		do_mark(0, 1);
		do_mark(0, 10);
		do_mark(0, 1023);
		do_mark(63, 1023);
		do_slot(ACT_SET, 0, 1, 4095);
		do_slot(ACT_SET, 0, 4, 0);
		do_slot(ACT_SET, 0, 5, 7);
		do_slot(ACT_RECLAIM, 0, 7, 0);
		do_slot(ACT_RECLAIM, 0, 4, 0);
		do_lookup(0, 24'd100);
		do_lookup(0, 24'd101);
		do_lookup(0, 24'd110);
		do_lookup(0, 24'd102);
		do_lookup(0, 24'd99);
		do_lookup(0, 24'd1124);
		do_lookup(0, 24'd1123);
		do_lookup(63, 24'hFFFFFF);
		r = '1;
		send_req(r);
		r.action = 3'd5;
		send_req(r);
		r = '1;
		r.action = 3'd6;
		send_req(r);
		calm = 1'b0;
	endtask

	// Dense fills that push ranks past the first block into the block slots, with a start page near the top
	task automatic test_slot_walk();
		int p;
		p = 5;
		do_header(p, 24'd0, 20'hFFF00 + 20'($urandom_range(255)));
		for (int sl = 0; sl <= BLOCKS_PER_PARTITION; sl++)
			do_slot(ACT_SET, p, sl, $urandom_range(4095));
		for (int i = 0; i < 1024; i += 1 + (i % 3 == 0)) do_mark(p, i);
		do_slot(ACT_RECLAIM, p, 2, 0);
		for (int i = 0; i < 40; i++) do_lookup(p, 24'($urandom_range(1023)));
		do_lookup(p, 24'd1022);
		do_lookup(p, 24'd1023);
	endtask

	// Mixed random traffic on a handful of partitions plus noise
	task automatic test_random(input int n);
		req_t r;
		int p;
		for (int i = 0; i < n; i++) begin
			calm = (i >= n/3 && i < n/2);
			p = $urandom_range(7);
			if (!hdr_set[p]) begin
				do_header(p, $urandom_range(1) ? 24'($urandom_range(2000)) : 24'($urandom),
					20'($urandom));
				continue;
			end
			r = '0;
			r.partition = 6'(p);
			r.lpn = 24'($urandom);
			r.page_offset = 10'($urandom);
			r.start_ppn = 20'($urandom);
			r.slot = 3'($urandom);
			r.block = 12'($urandom);
			case ($urandom_range(99)) inside
				[0:1]: begin
					r.action = ACT_HEADER;
					if ($urandom_range(1)) r.lpn = 24'($urandom_range(2000));
				end
				[2:44]: begin
					r.action = ACT_MARK;
					if ($urandom_range(9) != 0) r.page_offset = 10'($urandom_range(300));
				end
				[45:54]: begin
					r.action = ACT_SET;
					if ($urandom_range(7) != 0) r.slot = 3'($urandom_range(4));
				end
				[55:58]: r.action = ACT_RECLAIM;
				[59:96]: begin
					r.action = ACT_LOOKUP;
					if ($urandom_range(7) != 0)
						r.lpn = start_lpn_sh[p] + 24'($urandom_range(310));
				end
				default: r.action = 3'($urandom_range(5, 7));
			endcase
			send_req(r);
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		mismatches = 0;
		cycle_count = 0;
		calm = 1'b0;
		idle_pct = 35;
		for (int i = 0; i < NUM_PARTITIONS*WORDS_PP; i++) bitmap_sh[i] = '0;
		for (int i = 0; i < NUM_PARTITIONS*SLOTS_PP; i++) slot_sh[i] = SLOT_RECLAIMED;
		for (int i = 0; i < NUM_PARTITIONS; i++) begin
			start_lpn_sh[i] = '0;
			start_ppn_sh[i] = '0;
			hdr_set[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_slot_walk();
		test_random(1100);
		req_valid <= 1'b0;
		// Drain outstanding responses, then let the pipe settle
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_rsp_q.size() == 0)
			$display("partition_page_rank_translate test passed");
		else
			$display("partition_page_rank_translate test failed");
		$finish;
	end

endmodule
